// File: design/arx_pkg.sv
// ----------------------------------------------------------------------------
// arx_pkg: shared types and constants of the ARX model step unit
// Word formats of both channels, the configuration register set and the
// fixed-point constants used by the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package arx_pkg;

    // Fixed-point formats: samples Q8.8, coefficients Q2.14
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int FRAC_BITS    = 14;
    localparam int PACKED_COEFS = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    // Item kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INPUT_DELAY       = 3'd0,
        REG_FEEDBACK_ORDER    = 3'd1,
        REG_FEEDFORWARD_ORDER = 3'd2,
        REG_FEEDBACK_COEFS    = 3'd3,
        REG_FEEDFORWARD_COEFS = 3'd4
    } t_cfg_reg;

    // Input word
    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic signed [SAMPLE_W-1:0] disturbance;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] response;
        logic                       saturated;
    } t_out_word;

    // Configuration register set
    typedef struct packed {
        logic [3:0]                  input_delay;
        logic [2:0]                  feedback_order;
        logic [2:0]                  feedforward_order;
        logic [PACKED_COEFS*COEF_W-1:0] feedback_coefs;
        logic [PACKED_COEFS*COEF_W-1:0] feedforward_coefs;
    } t_cfg;

endpackage

// File: design/arx_model_step_unit.sv
// ----------------------------------------------------------------------------
// arx_model_step_unit: ARX process model, one response per sample word
// Input and output histories with a configurable transport delay, orders
// and Q2.14 coefficients; Q8.8 samples with rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries t_in_word. A sample word
//   yields one t_out_word on o_out_valid / i_out_ready; a clear word zeroes
//   both histories and yields nothing.
//   An accepted word waits in the input register; its result is computed
//   combinationally and written to the result register. Throughput: one
//   word per cycle unless the receiver stalls. It is set by the feedback
//   loop: the combinational multiply-accumulate, rounding and clipping of
//   one sample write the output history before the next one is computed.
//   The configuration port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) writes
//   a register at any edge with the enable high; write it only while idle.
//   Reset (synchronous, active low) empties both stages, zeroes both
//   histories and restores the register defaults (delay 1, orders 0).
//   When the receiver stalls, the result register holds its word; the
//   input register still takes one more word, then o_in_ready drops.
// ----------------------------------------------------------------------------
module arx_model_step_unit #(
    parameter int MAX_FEEDBACK    = 4,
    parameter int MAX_FEEDFORWARD = 4,
    parameter int MAX_DELAY       = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  arx_pkg::t_in_word                     i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output arx_pkg::t_out_word                    o_out_word,
    input  logic                                  i_cfg_wr_en,
    input  logic [arx_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [arx_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    localparam int IN_DEPTH = MAX_DELAY + MAX_FEEDFORWARD;

    arx_pkg::t_cfg                         r_cfg;
    logic                                  r_in_valid;
    arx_pkg::t_in_word                     r_in_word;
    logic                                  r_out_valid;
    arx_pkg::t_out_word                    r_out_word;
    logic signed [arx_pkg::SAMPLE_W-1:0]   r_in_hist  [IN_DEPTH];
    logic signed [arx_pkg::SAMPLE_W-1:0]   r_out_hist [MAX_FEEDBACK];

    logic                                  w_is_clear;
    logic                                  w_advance;
    logic                                  w_in_take;
    arx_pkg::t_out_word                    w_sum_word;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_delay       <= 4'd1;
            r_cfg.feedback_order    <= 3'd0;
            r_cfg.feedforward_order <= 3'd0;
            r_cfg.feedback_coefs    <= '0;
            r_cfg.feedforward_coefs <= '0;
        end else if (i_cfg_wr_en) begin
            case (arx_pkg::t_cfg_reg'(i_cfg_index))
                arx_pkg::REG_INPUT_DELAY: begin
                    r_cfg.input_delay <= i_cfg_wdata[3:0];
                end
                arx_pkg::REG_FEEDBACK_ORDER: begin
                    r_cfg.feedback_order <= i_cfg_wdata[2:0];
                end
                arx_pkg::REG_FEEDFORWARD_ORDER: begin
                    r_cfg.feedforward_order <= i_cfg_wdata[2:0];
                end
                arx_pkg::REG_FEEDBACK_COEFS: begin
                    r_cfg.feedback_coefs <= i_cfg_wdata;
                end
                arx_pkg::REG_FEEDFORWARD_COEFS: begin
                    r_cfg.feedforward_coefs <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: advance the held word when it is a clear or the result register can take it
    assign w_is_clear = (r_in_word.kind == arx_pkg::KIND_CLEAR);
    assign w_advance  = r_in_valid && (w_is_clear || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // Multiply-accumulate datapath
    arx_sum #(
        .MAX_FEEDBACK    (MAX_FEEDBACK),
        .MAX_FEEDFORWARD (MAX_FEEDFORWARD),
        .MAX_DELAY       (MAX_DELAY)
    ) u_sum (
        .i_cfg         (r_cfg),
        .i_in_hist     (r_in_hist),
        .i_out_hist    (r_out_hist),
        .i_disturbance (r_in_word.disturbance),
        .o_word        (w_sum_word)
    );

    // Histories: shift on a sample, zero on a clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < IN_DEPTH; k++) begin
                r_in_hist[k] <= '0;
            end
            for (int k = 0; k < MAX_FEEDBACK; k++) begin
                r_out_hist[k] <= '0;
            end
        end else if (w_advance) begin
            if (w_is_clear) begin
                for (int k = 0; k < IN_DEPTH; k++) begin
                    r_in_hist[k] <= '0;
                end
                for (int k = 0; k < MAX_FEEDBACK; k++) begin
                    r_out_hist[k] <= '0;
                end
            end else begin
                for (int k = IN_DEPTH - 1; k > 0; k--) begin
                    r_in_hist[k] <= r_in_hist[k-1];
                end
                r_in_hist[0] <= r_in_word.sample_in;
                for (int k = MAX_FEEDBACK - 1; k > 0; k--) begin
                    r_out_hist[k] <= r_out_hist[k-1];
                end
                r_out_hist[0] <= w_sum_word.response;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && !w_is_clear) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && !w_is_clear) begin
            r_out_word <= w_sum_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A sample leaving the input register shows up as a result next cycle
    a_sample_to_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !w_is_clear |=> o_out_valid)
        else $error("sample word advanced without a result");

    // A clear zeroes the newest entry of both histories
    a_clear_zeroes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_is_clear |=> (r_in_hist[0] == '0) && (r_out_hist[0] == '0))
        else $error("clear word left history data");

    // The saturation flag only comes with a clipped response
    a_sat_extreme : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.saturated |->
            (o_out_word.response == 16'sh7FFF) || (o_out_word.response == 16'sh8000))
        else $error("saturation flag on an unclipped response");

    // A full input stage waits only on a stalled result of a sample word
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_in_ready |-> o_out_valid && !i_out_ready && !w_is_clear)
        else $error("input stage blocked without a stalled result");

endmodule

// File: design/arx_sum.sv
// ----------------------------------------------------------------------------
// arx_sum: ARX multiply-accumulate, rounding and saturation
// Forms sum b_i*u[n-d-i] - sum a_j*y[n-1-j] + disturbance at Q15.22 from
// the stored histories, rounds half up, shifts to Q8.8 and clips to 16 bits.
// ----------------------------------------------------------------------------
module arx_sum #(
    parameter int MAX_FEEDBACK    = 4,
    parameter int MAX_FEEDFORWARD = 4,
    parameter int MAX_DELAY       = 8
) (
    input  arx_pkg::t_cfg                              i_cfg,
    input  logic signed [arx_pkg::SAMPLE_W-1:0]        i_in_hist  [MAX_DELAY+MAX_FEEDFORWARD],
    input  logic signed [arx_pkg::SAMPLE_W-1:0]        i_out_hist [MAX_FEEDBACK],
    input  logic signed [arx_pkg::SAMPLE_W-1:0]        i_disturbance,
    output arx_pkg::t_out_word                         o_word
);

    localparam int IN_DEPTH = MAX_DELAY + MAX_FEEDFORWARD;
    localparam int IDX_W    = $clog2(IN_DEPTH);
    localparam int PROD_W   = arx_pkg::SAMPLE_W + arx_pkg::COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(MAX_FEEDBACK + MAX_FEEDFORWARD + 2) + 1;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (arx_pkg::FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] Y_MAX      = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN      = ACC_W'(-32768);

    logic [7:0]                      w_delay;
    logic [7:0]                      w_base;
    logic signed [PROD_W-1:0]        w_ff_prod [MAX_FEEDFORWARD];
    logic signed [PROD_W-1:0]        w_fb_prod [MAX_FEEDBACK];
    logic signed [ACC_W-1:0]         w_acc;
    logic signed [ACC_W-1:0]         w_shifted;

    // Clamp the delay to 1..MAX_DELAY; tap i reads the pre-push entry d-1+i
    always_comb begin
        if (i_cfg.input_delay == 4'd0) begin
            w_delay = 8'd1;
        end else if ({4'd0, i_cfg.input_delay} > 8'(MAX_DELAY)) begin
            w_delay = 8'(MAX_DELAY);
        end else begin
            w_delay = {4'd0, i_cfg.input_delay};
        end
        w_base = w_delay - 8'd1;
    end

    // Feed-forward products, gated by the order
    for (genvar i = 0; i < MAX_FEEDFORWARD; i++) begin : g_ff
        if (i < arx_pkg::PACKED_COEFS) begin : g_coef
            logic [7:0]                         w_idx;
            logic signed [arx_pkg::COEF_W-1:0]  w_coef;
            logic signed [PROD_W-1:0]           w_prod;
            logic                               w_on;
            assign w_idx  = w_base + 8'(i);
            assign w_coef = i_cfg.feedforward_coefs[arx_pkg::COEF_W*i +: arx_pkg::COEF_W];
            assign w_prod = w_coef * i_in_hist[w_idx[IDX_W-1:0]];
            assign w_on   = 8'(i) < {5'd0, i_cfg.feedforward_order};
            assign w_ff_prod[i] = w_on ? w_prod : '0;
        end else begin : g_zero
            assign w_ff_prod[i] = '0;
        end
    end

    // Feedback products, gated by the order
    for (genvar j = 0; j < MAX_FEEDBACK; j++) begin : g_fb
        if (j < arx_pkg::PACKED_COEFS) begin : g_coef
            logic signed [arx_pkg::COEF_W-1:0]  w_coef;
            logic signed [PROD_W-1:0]           w_prod;
            logic                               w_on;
            assign w_coef = i_cfg.feedback_coefs[arx_pkg::COEF_W*j +: arx_pkg::COEF_W];
            assign w_prod = w_coef * i_out_hist[j];
            assign w_on   = 8'(j) < {5'd0, i_cfg.feedback_order};
            assign w_fb_prod[j] = w_on ? w_prod : '0;
        end else begin : g_zero
            assign w_fb_prod[j] = '0;
        end
    end

    // Accumulate at Q15.22
    always_comb begin
        w_acc = ACC_W'(i_disturbance) <<< arx_pkg::FRAC_BITS;
        for (int i = 0; i < MAX_FEEDFORWARD; i++) begin
            w_acc = w_acc + ACC_W'(w_ff_prod[i]);
        end
        for (int j = 0; j < MAX_FEEDBACK; j++) begin
            w_acc = w_acc - ACC_W'(w_fb_prod[j]);
        end
    end

    // Round half up, drop fraction bits, clip to 16 bits
    always_comb begin
        w_shifted = (w_acc + ROUND_HALF) >>> arx_pkg::FRAC_BITS;
        if (w_shifted > Y_MAX) begin
            o_word.response  = 16'sh7FFF;
            o_word.saturated = 1'b1;
        end else if (w_shifted < Y_MIN) begin
            o_word.response  = 16'sh8000;
            o_word.saturated = 1'b1;
        end else begin
            o_word.response  = w_shifted[arx_pkg::SAMPLE_W-1:0];
            o_word.saturated = 1'b0;
        end
    end

endmodule
